// File: hw/rtl/mrd_pkg.sv
// Package for the CRC-8 checked motor reply deframer.
// Holds shared constants, the result and status structs and the CRC-8 byte step.
// No dependencies.
package mrd_pkg;

    localparam int PACKET_BYTES_DEF = 10;
    localparam int POS_W            = 4;
    localparam int STORE_DEPTH      = 8;
    localparam int STORE_IDX_W      = 3;
    localparam int MAX_DATA         = 7;
    localparam int PAYLOAD_W        = 8 * MAX_DATA;

    localparam logic [7:0] CRC_INIT    = 8'h00;
    localparam logic [7:0] REFL_POLY   = 8'h8C;
    localparam logic [7:0] DEV_ID_RST  = 8'h00;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           command_byte;
        logic [PAYLOAD_W-1:0] payload;
    } t_mrd_result;

    typedef struct packed {
        logic hunting;
        logic at_check;
    } t_mrd_status;

    // One byte of CRC-8/MAXIM, reflected form, processed LSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ REFL_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/mrd_rx_if.sv
// Valid/ready channel that carries one received serial byte.
// No dependencies.
interface mrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/mrd_res_if.sv
// Valid/ready channel that carries one accepted packet: command byte and data bytes.
// No dependencies.
interface mrd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_byte;
    logic [55:0] payload;

    modport source (output valid, output command_byte, output payload, input ready);
    modport sink   (input valid, input command_byte, input payload, output ready);
endinterface

// File: hw/rtl/mrd_frame.sv
// Framing core: byte position, running CRC-8 and the packet byte store.
// Depends on mrd_pkg.
module mrd_frame #(
    parameter int PACKET_BYTES = mrd_pkg::PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_device_id,
    output mrd_pkg::t_mrd_result o_result,
    output mrd_pkg::t_mrd_status o_status
);
    import mrd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
    localparam int NDATA = (PACKET_BYTES - 3 > MAX_DATA) ? MAX_DATA : (PACKET_BYTES - 3);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_store [STORE_DEPTH];
    logic [POS_W-1:0] w_slot;
    logic             w_hunting;
    logic             w_at_check;
    logic [7:0]       w_crc_step;

    assign w_hunting  = (r_pos == '0);
    assign w_at_check = (r_pos == LAST_POS);
    assign w_slot     = r_pos - POS_W'(1);
    // While hunting the CRC restarts from its initial value.
    assign w_crc_step = crc8_step(w_hunting ? CRC_INIT : r_crc, i_byte);

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (i_step) begin
            if (w_hunting) begin
                if (i_byte == i_device_id) begin
                    n_pos = POS_W'(1);
                    n_crc = w_crc_step;
                end
            end else if (w_at_check) begin
                n_pos = '0;
                n_crc = CRC_INIT;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_crc = w_crc_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Bytes past the store depth only feed the CRC.
    always_ff @(posedge i_clk) begin
        if (i_step && !w_hunting && !w_at_check && !w_slot[POS_W-1]) begin
            r_store[w_slot[STORE_IDX_W-1:0]] <= i_byte;
        end
    end

    always_comb begin
        o_result.valid        = i_step && w_at_check && (i_byte == r_crc);
        o_result.command_byte = r_store[0];
        o_result.payload      = '0;
        for (int i = 0; i < MAX_DATA; i++) begin
            if (i < NDATA) begin
                o_result.payload[8*i +: 8] = r_store[i+1];
            end
        end
    end

    assign o_status.hunting  = w_hunting;
    assign o_status.at_check = w_at_check;

endmodule

// File: hw/rtl/motor_reply_deframer_crc8.sv
// Top level of the CRC-8 checked motor reply deframer.
// Depends on mrd_pkg, mrd_rx_if, mrd_res_if and mrd_frame.
//
// Accepts one received byte per clock cycle while the result channel does not stall, and
// registers a packet result when its check byte is processed. Each byte passes through an
// input register, one table-free CRC-8 byte step and position update, and an output
// register; that single stage sets the rate. Bytes that do not equal the device id are
// discarded while hunting. A packet of PACKET_BYTES bytes (id, command, data, check) gives
// one transfer on the result channel when the check byte matches the CRC-8/MAXIM over the
// preceding bytes; otherwise it is dropped. Data bytes fill the payload from the low byte
// up, and unused high bytes read zero. Write the device id only while the block is idle.
module motor_reply_deframer_crc8 #(
    parameter int PACKET_BYTES = mrd_pkg::PACKET_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    mrd_rx_if.sink           i_rx,
    mrd_res_if.source        o_res
);
    import mrd_pkg::*;

    logic                  r_device_id;
    logic [7:0]            r_dev_id;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [7:0]            r_out_cmd;
    logic [PAYLOAD_W-1:0]  r_out_payload;
    logic                  w_step;
    t_mrd_result           w_res;
    t_mrd_status           w_status;

    assign w_step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id    <= DEV_ID_RST;
            r_device_id <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_dev_id    <= i_cfg_wr_data;
            r_device_id <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mrd_frame #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_device_id (r_dev_id),
        .o_result    (w_res),
        .o_status    (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.valid) begin
            r_out_cmd     <= w_res.command_byte;
            r_out_payload <= w_res.payload;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.command_byte = r_out_cmd;
    assign o_res.payload      = r_out_payload;

    // A result can only come from a check byte being processed.
    a_res_at_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (w_step && w_status.at_check))
        else $error("result raised outside the check byte");

    // After the check byte the deframer always goes back to hunting.
    a_check_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_status.at_check) |=> w_status.hunting)
        else $error("deframer did not return to hunting after the check byte");

    // Without a processed byte the framing position does not leave hunting.
    a_hunt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_step && w_status.hunting) |=> w_status.hunting)
        else $error("framing position moved without a byte");

    // A new pending result needs a byte stepped in the cycle before.
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !$past(o_res.valid)) |-> $past(w_step))
        else $error("result appeared without a processed byte");

    // The device id register only changes on a configuration write.
    a_cfg_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_cfg_wr_en) && $past(r_device_id)) |-> $stable(r_dev_id))
        else $error("device id changed without a write");

endmodule
